>>> src/fsc_pkg.sv
// Shared word types and result codes for the frame receiver sequence checker.
package fsc_pkg;

   // Frame end status codes
   localparam logic [2:0] ST_OK            = 3'd0;
   localparam logic [2:0] ST_DROPPED       = 3'd1;
   localparam logic [2:0] ST_OVERFLOW      = 3'd2;
   localparam logic [2:0] ST_DATA_IN_FOOT  = 3'd3;
   localparam logic [2:0] ST_DROP_IN_FOOT  = 3'd4;
   localparam logic [2:0] ST_OVF_IN_FOOT   = 3'd5;

   // Sequence check codes
   localparam logic [1:0] SEQ_IN_ORDER  = 2'd0;
   localparam logic [1:0] SEQ_GAP       = 2'd1;
   localparam logic [1:0] SEQ_FRAME_ERR = 2'd2;

   // Footer terminator byte
   localparam logic [7:0] FOOTER_END_BYTE = 8'hFF;

   typedef struct packed {
      logic       frame_valid;
      logic       marker;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic        ack_level;
      logic        frame_end;
      logic [2:0]  status;
      logic [15:0] head;
      logic [1:0]  sequence_result;
      logic [31:0] miss_count;
      logic [31:0] error_count;
      logic [31:0] good_count;
   } rsp_word_type;

   // Frame close information from the framing tracker
   typedef struct packed {
      logic        ack_level;
      logic        frame_end;
      logic [2:0]  status;
      logic [15:0] head;
   } close_info_type;

endpackage

>>> src/fsc_frame_tracker.sv
// Frame delimiting, footer tracking, head byte capture and acknowledge toggle.
module fsc_frame_tracker #(
   parameter int FRAME_WORDS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  fsc_pkg::req_word_type word,
   output fsc_pkg::close_info_type info
);
   import fsc_pkg::*;

   localparam int IDX_W = $clog2(FRAME_WORDS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_WORDS - 1);
   localparam logic [IDX_W-1:0] HEAD_LO_IDX = IDX_W'(1);
   localparam logic [IDX_W-1:0] HEAD_HI_IDX = IDX_W'(2);

   logic             in_frame_ff, in_frame_in;
   logic             footer_ff, footer_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             ack_ff, ack_in;
   logic [7:0]       head_lo_ff, head_lo_in;
   logic [7:0]       head_hi_ff, head_hi_in;

   logic [IDX_W-1:0] eff_idx;
   logic             eff_footer;
   logic             footer_now;
   logic             closing;
   logic [2:0]       status;

   // Word position and footer as seen by this word (a new frame starts at word 0)
   assign eff_idx    = in_frame_ff ? idx_ff : '0;
   assign eff_footer = in_frame_ff & footer_ff;
   assign footer_now = eff_footer | word.marker;

   // Framing decision for one word
   always_comb begin
      in_frame_in = in_frame_ff;
      footer_in   = footer_ff;
      idx_in      = idx_ff;
      ack_in      = ack_ff;
      head_lo_in  = head_lo_ff;
      head_hi_in  = head_hi_ff;
      closing     = 1'b0;
      status      = ST_OK;
      if (word.frame_valid || in_frame_ff) begin
         if (eff_idx == HEAD_LO_IDX) begin
            head_lo_in = word.data_byte;
         end
         if (eff_idx == HEAD_HI_IDX) begin
            head_hi_in = word.data_byte;
         end
      end
      if (!word.frame_valid) begin
         if (in_frame_ff) begin
            closing = 1'b1;
            status  = footer_ff ? ST_DROP_IN_FOOT : ST_DROPPED;
         end
      end else begin
         in_frame_in = 1'b1;
         ack_in      = ~ack_ff;
         footer_in   = footer_now;
         if (eff_footer) begin
            if (!word.marker) begin
               closing = 1'b1;
               status  = ST_DATA_IN_FOOT;
            end else if (word.data_byte == FOOTER_END_BYTE) begin
               closing = 1'b1;
               status  = ST_OK;
            end
         end
         if (!closing) begin
            idx_in = eff_idx + IDX_W'(1);
            if (eff_idx == LAST_IDX) begin
               closing = 1'b1;
               status  = footer_now ? ST_OVF_IN_FOOT : ST_OVERFLOW;
            end
         end
      end
      if (closing) begin
         in_frame_in = 1'b0;
         footer_in   = 1'b0;
         idx_in      = '0;
      end
   end

   // Close information toward the sequence check
   always_comb begin
      info.ack_level = ack_in;
      info.frame_end = closing;
      info.status    = status;
      info.head      = {head_hi_in, head_lo_in};
   end

   // Tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         footer_ff   <= 1'b0;
         idx_ff      <= '0;
         ack_ff      <= 1'b0;
         head_lo_ff  <= '0;
         head_hi_ff  <= '0;
      end else if (step) begin
         in_frame_ff <= in_frame_in;
         footer_ff   <= footer_in;
         idx_ff      <= idx_in;
         ack_ff      <= ack_in;
         head_lo_ff  <= head_lo_in;
         head_hi_ff  <= head_hi_in;
      end
   end

endmodule

>>> src/frame_receiver_sequence_checker.sv
// Top level: frame receiver with head counter sequence check and frame counters.
//
// channel | direction | handshake            | word
// req     | in        | req_valid/req_ready  | frame_valid, marker, data_byte
// rsp     | out       | rsp_valid/rsp_ready  | ack, frame end, status, head, seq, counters
//
// One result word per input word. Each word passes through an input register, then
// framing and sequence logic into the result register. One word per cycle is
// sustained while results are taken, set by the single add of the counter update.
// Synchronous reset clears framing state, head bytes, previous head and counters.
// A stalled result holds the result register; the input register keeps
// accepting until both stages are full.
module frame_receiver_sequence_checker #(
   parameter int FRAME_WORDS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fsc_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fsc_pkg::rsp_word_type rsp_data
);
   import fsc_pkg::*;

   logic           s1_valid_ff;
   req_word_type   s1_word_ff;
   logic           rsp_valid_ff;
   rsp_word_type   rsp_ff, rsp_in;
   logic           out_free;
   logic           advance;

   close_info_type info;
   logic [15:0]    prev_head_ff;
   logic [31:0]    miss_ff, error_ff, good_ff;
   logic [31:0]    miss_in, error_in, good_in;
   logic [31:0]    miss_inc;
   logic [1:0]     seq;
   logic           in_seq;

   // Flow control
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_word_ff <= req_data;
      end
   end

   fsc_frame_tracker #(
      .FRAME_WORDS(FRAME_WORDS)
   ) u_tracker (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .word  (s1_word_ff),
      .info  (info)
   );

   // Sequence check on the closed frame's head
   assign in_seq   = (info.head == prev_head_ff + 16'd1);
   assign miss_inc = (info.head > prev_head_ff)
                   ? ({16'd0, info.head} - {16'd0, prev_head_ff} + 32'd1)
                   : ({16'd0, info.head} + 32'd65536 - {16'd0, prev_head_ff});

   always_comb begin
      miss_in  = miss_ff;
      error_in = error_ff;
      good_in  = good_ff;
      seq      = SEQ_IN_ORDER;
      if (info.frame_end) begin
         priority if (info.status != ST_OK) begin
            error_in = error_ff + 32'd1;
            seq      = SEQ_FRAME_ERR;
         end else if (!in_seq) begin
            miss_in = miss_ff + miss_inc;
            seq     = SEQ_GAP;
         end else begin
            good_in = good_ff + 32'd1;
         end
      end
   end

   // Result word
   always_comb begin
      rsp_in.ack_level       = info.ack_level;
      rsp_in.frame_end       = info.frame_end;
      rsp_in.status          = info.frame_end ? info.status : ST_OK;
      rsp_in.head            = info.frame_end ? info.head : 16'd0;
      rsp_in.sequence_result = seq;
      rsp_in.miss_count      = miss_in;
      rsp_in.error_count     = error_in;
      rsp_in.good_count      = good_in;
   end

   // Sequence state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_head_ff <= '0;
         miss_ff      <= '0;
         error_ff     <= '0;
         good_ff      <= '0;
      end else if (advance) begin
         if (info.frame_end) begin
            prev_head_ff <= info.head;
         end
         miss_ff  <= miss_in;
         error_ff <= error_in;
         good_ff  <= good_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Checks
   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.frame_end |->
         rsp_data.status == ST_OK && rsp_data.head == 16'd0 &&
         rsp_data.sequence_result == SEQ_IN_ORDER)
      else $error("fields not cleared on a word without frame end");

   a_error_status_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end && rsp_data.status != ST_OK |->
         rsp_data.sequence_result == SEQ_FRAME_ERR)
      else $error("error status without frame error result");

   a_good_count_step: assert property (@(posedge clock) disable iff (reset)
      advance && info.frame_end && seq == SEQ_IN_ORDER && info.status == ST_OK |=>
         good_ff == $past(good_ff) + 32'd1)
      else $error("good counter did not advance on an in-order frame");

endmodule
